// ----- rtl/gbnms_pkg.sv -----
// Shared types and constants for the greedy box NMS unit.
// Used by the top level and its checker; no dependencies.
package gbnms_pkg;

  localparam int KeptDepthDefault = 32;
  localparam int MaxMerges        = 32;
  localparam int MergeCntW        = 6;

  localparam int CoordW = 13;
  localparam int SizeW  = 12;
  localparam int ScoreW = 16;
  localparam int LabelW = 5;
  localparam int SlotW  = 5;
  localparam int AreaW  = 24;
  localparam int UniW   = 26;
  localparam int ThrW   = 16;
  localparam int ProdW  = ThrW + UniW;

  localparam int InDataW  = 72;
  localparam int OutDataW = 8;
  localparam int CfgIdxW  = 2;

  localparam logic [ThrW-1:0] NmsThrReset   = 16'd19661;
  localparam logic [ThrW-1:0] MergeIouReset = 16'd58982;
  localparam logic [ThrW-1:0] MergeGapReset = 16'd9830;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_NMS_THR   = 2'd0,
    CFG_MERGE_IOU = 2'd1,
    CFG_MERGE_GAP = 2'd2
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_AREA,
    S_READ,
    S_GEO,
    S_INTER,
    S_BAREA,
    S_THR,
    S_MRG,
    S_FINAL
  } state_t;

  // one kept detection as stored in the RAM
  typedef struct packed {
    logic [LabelW-1:0] label;  // color[4:3], class[2:0]
    logic [ScoreW-1:0] score;
    logic [SizeW-1:0]  h;
    logic [SizeW-1:0]  w;
    logic [CoordW-1:0] y;
    logic [CoordW-1:0] x;
  } kept_entry_t;

endpackage

// ----- rtl/greedy_box_nms_with_merge_unit.sv -----
// Greedy box NMS with merge notices: top level, sequencer and shared multiplier.
// Depends on gbnms_pkg and gbnms_ram.
// Flow: a detection is taken only in idle; after its area, every box kept so far in the
//   frame (0..KEPT_DEPTH) is compared in turn, and output stalls can hold the walk.
//   Each kept box needs one RAM read and four passes through the one 16x26 multiplier.
// Reset (rst, synchronous): empties the kept store, loads register defaults,
//   drops any pending output. Stored box contents are not cleared.
module greedy_box_nms_with_merge_unit #(
  parameter int KEPT_DEPTH = gbnms_pkg::KeptDepthDefault
) (
  input  logic                              clk,
  input  logic                              rst,
  // detection input
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // [12:0] box_x, [25:13] box_y, [37:26] box_w, [49:38] box_h,
  // [65:50] score, [68:66] class_id, [70:69] color_id, [71] zero
  input  logic [gbnms_pkg::InDataW-1:0]     s_tdata,
  input  logic                              s_tuser,   // frame_start
  // result output
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // [4:0] slot, [5] kept, [6] store_full, [7] zero
  output logic [gbnms_pkg::OutDataW-1:0]    m_tdata,
  output logic                              m_tuser,   // is_merge
  output logic                              m_tlast,   // last
  // register writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [gbnms_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [gbnms_pkg::ThrW-1:0]        cfg_data
);

  localparam int CNT_W = $clog2(KEPT_DEPTH + 1);
  localparam int IDX_W = KEPT_DEPTH > 1 ? $clog2(KEPT_DEPTH) : 1;
  localparam int ENT_W = $bits(gbnms_pkg::kept_entry_t);

  gbnms_pkg::state_t state, state_next;

  // configuration registers
  logic [gbnms_pkg::ThrW-1:0] nms_thr, mrg_iou, mrg_gap;

  // current detection
  logic signed [gbnms_pkg::CoordW-1:0] a_x, a_y;
  logic [gbnms_pkg::SizeW-1:0]         a_w, a_h;
  logic [gbnms_pkg::ScoreW-1:0]        a_score;
  logic [gbnms_pkg::LabelW-1:0]        a_label;
  logic [gbnms_pkg::AreaW-1:0]         area_a;

  // scan state
  logic [CNT_W-1:0]                    cnt, idx;
  logic [gbnms_pkg::MergeCntW-1:0]     merges;
  logic                                keep_flag;

  // per-comparison work registers
  logic [gbnms_pkg::SizeW-1:0]         dx, dy;
  logic [gbnms_pkg::AreaW-1:0]         inter;
  logic [gbnms_pkg::UniW-1:0]          uni;
  logic                                over_r;

  // kept store
  gbnms_pkg::kept_entry_t              rd_ent, wr_ent;
  logic [ENT_W-1:0]                    rd_raw;
  logic                                ram_we, ram_re;

  // shared multiplier
  logic [gbnms_pkg::ThrW-1:0]          mul_a;
  logic [gbnms_pkg::UniW-1:0]          mul_b;
  logic [gbnms_pkg::ProdW-1:0]         prod;
  logic [gbnms_pkg::ProdW-1:0]         inter_sh;

  // geometry
  logic signed [gbnms_pkg::CoordW-1:0] b_x, b_y, x1, y1;
  logic signed [gbnms_pkg::CoordW:0]   a_r, a_b, b_r, b_b, x2, y2;
  logic signed [gbnms_pkg::CoordW+1:0] dxs, dys;

  // decisions
  logic                                zero_uni, mrg_iou_hit, sup, merge_hit;
  logic [gbnms_pkg::ScoreW-1:0]        sdiff;
  logic                                out_free, can_store;
  logic                                load_merge, load_final;
  logic [CNT_W-1:0]                    idx_inc;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == gbnms_pkg::S_IDLE);

  // register writes; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (rst) begin
      nms_thr <= gbnms_pkg::NmsThrReset;
      mrg_iou <= gbnms_pkg::MergeIouReset;
      mrg_gap <= gbnms_pkg::MergeGapReset;
    end else if (cfg_valid) begin
      case (cfg_index)
        gbnms_pkg::CFG_NMS_THR:   nms_thr <= cfg_data;
        gbnms_pkg::CFG_MERGE_IOU: mrg_iou <= cfg_data;
        gbnms_pkg::CFG_MERGE_GAP: mrg_gap <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Kept store
  // ---------------------------------------------------------------------------
  assign ram_re = (state == gbnms_pkg::S_READ);
  assign rd_ent = gbnms_pkg::kept_entry_t'(rd_raw);

  always_comb begin
    wr_ent.x     = a_x;
    wr_ent.y     = a_y;
    wr_ent.w     = a_w;
    wr_ent.h     = a_h;
    wr_ent.score = a_score;
    wr_ent.label = a_label;
  end

  gbnms_ram #(
    .WIDTH (ENT_W),
    .DEPTH (KEPT_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt[IDX_W-1:0]),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (idx[IDX_W-1:0]),
    .rdata (rd_raw)
  );

  // ---------------------------------------------------------------------------
  // Shared multiplier: area, intersection, kept area, then both thresholds
  // ---------------------------------------------------------------------------
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      gbnms_pkg::S_AREA: begin
        mul_a = {4'b0, a_w};
        mul_b = {14'b0, a_h};
      end
      gbnms_pkg::S_INTER: begin
        mul_a = {4'b0, dx};
        mul_b = {14'b0, dy};
      end
      gbnms_pkg::S_BAREA: begin
        mul_a = {4'b0, rd_ent.w};
        mul_b = {14'b0, rd_ent.h};
      end
      gbnms_pkg::S_THR: begin
        mul_a = nms_thr;
        mul_b = uni;
      end
      gbnms_pkg::S_MRG: begin
        mul_a = mrg_iou;
        mul_b = uni;
      end
      default: ;
    endcase
  end

  assign prod     = mul_a * mul_b;
  assign inter_sh = {2'b0, inter, 16'b0};   // inter * 65536

  // ---------------------------------------------------------------------------
  // Overlap geometry against the kept box just read
  // ---------------------------------------------------------------------------
  always_comb begin
    b_x = $signed(rd_ent.x);
    b_y = $signed(rd_ent.y);
    a_r = {a_x[gbnms_pkg::CoordW-1], a_x} + $signed({2'b0, a_w});
    a_b = {a_y[gbnms_pkg::CoordW-1], a_y} + $signed({2'b0, a_h});
    b_r = {b_x[gbnms_pkg::CoordW-1], b_x} + $signed({2'b0, rd_ent.w});
    b_b = {b_y[gbnms_pkg::CoordW-1], b_y} + $signed({2'b0, rd_ent.h});
    x1  = (a_x > b_x) ? a_x : b_x;
    y1  = (a_y > b_y) ? a_y : b_y;
    x2  = (a_r < b_r) ? a_r : b_r;
    y2  = (a_b < b_b) ? a_b : b_b;
    dxs = {x2[gbnms_pkg::CoordW], x2} - {{2{x1[gbnms_pkg::CoordW-1]}}, x1};
    dys = {y2[gbnms_pkg::CoordW], y2} - {{2{y1[gbnms_pkg::CoordW-1]}}, y1};
  end

  // ---------------------------------------------------------------------------
  // Suppress / merge decision
  // ---------------------------------------------------------------------------
  assign zero_uni    = (uni == '0);
  assign mrg_iou_hit = inter_sh > prod;
  assign sup         = zero_uni || over_r;
  assign sdiff       = (a_score > rd_ent.score) ? a_score - rd_ent.score
                                                : rd_ent.score - a_score;
  assign merge_hit   = !zero_uni && over_r && mrg_iou_hit && (sdiff < mrg_gap) &&
                       (rd_ent.label == a_label) &&
                       (merges < gbnms_pkg::MergeCntW'(gbnms_pkg::MaxMerges));
  assign out_free    = !m_tvalid || m_tready;
  assign can_store   = keep_flag && (cnt < CNT_W'(KEPT_DEPTH));
  assign idx_inc     = idx + CNT_W'(1);

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gbnms_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    load_merge = 1'b0;
    load_final = 1'b0;
    ram_we     = 1'b0;
    unique case (state)
      gbnms_pkg::S_IDLE: begin
        if (s_tvalid) begin
          state_next = gbnms_pkg::S_AREA;
        end
      end
      gbnms_pkg::S_AREA: begin
        state_next = (cnt == '0) ? gbnms_pkg::S_FINAL : gbnms_pkg::S_READ;
      end
      gbnms_pkg::S_READ:  state_next = gbnms_pkg::S_GEO;
      gbnms_pkg::S_GEO:   state_next = gbnms_pkg::S_INTER;
      gbnms_pkg::S_INTER: state_next = gbnms_pkg::S_BAREA;
      gbnms_pkg::S_BAREA: state_next = gbnms_pkg::S_THR;
      gbnms_pkg::S_THR:   state_next = gbnms_pkg::S_MRG;
      gbnms_pkg::S_MRG: begin
        // a merge notice waits for room in the output register
        if (!merge_hit || out_free) begin
          load_merge = merge_hit;
          state_next = (idx_inc == cnt) ? gbnms_pkg::S_FINAL : gbnms_pkg::S_READ;
        end
      end
      gbnms_pkg::S_FINAL: begin
        if (out_free) begin
          load_final = 1'b1;
          ram_we     = can_store;
          state_next = gbnms_pkg::S_IDLE;
        end
      end
      default: state_next = gbnms_pkg::S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Datapath
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == gbnms_pkg::S_IDLE && s_tvalid && s_tuser) begin
      cnt <= '0;
    end else if (ram_we) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      gbnms_pkg::S_IDLE: begin
        a_x       <= $signed(s_tdata[12:0]);
        a_y       <= $signed(s_tdata[25:13]);
        a_w       <= s_tdata[37:26];
        a_h       <= s_tdata[49:38];
        a_score   <= s_tdata[65:50];
        a_label   <= s_tdata[70:66];
        idx       <= '0;
        merges    <= '0;
        keep_flag <= 1'b1;
      end
      gbnms_pkg::S_AREA:  area_a <= prod[gbnms_pkg::AreaW-1:0];
      gbnms_pkg::S_GEO: begin
        if (dxs > 0 && dys > 0) begin
          dx <= dxs[gbnms_pkg::SizeW-1:0];
          dy <= dys[gbnms_pkg::SizeW-1:0];
        end else begin
          dx <= '0;
          dy <= '0;
        end
      end
      gbnms_pkg::S_INTER: inter <= prod[gbnms_pkg::AreaW-1:0];
      gbnms_pkg::S_BAREA: begin
        // union never goes negative: inter is at most either area
        uni <= {2'b0, area_a} + {2'b0, prod[gbnms_pkg::AreaW-1:0]} - {2'b0, inter};
      end
      gbnms_pkg::S_THR:   over_r <= inter_sh > prod;
      gbnms_pkg::S_MRG: begin
        if (!merge_hit || out_free) begin
          idx <= idx_inc;
          if (sup) begin
            keep_flag <= 1'b0;
          end
          if (merge_hit) begin
            merges <= merges + gbnms_pkg::MergeCntW'(1);
          end
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load_merge || load_final) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_merge) begin
      m_tuser <= 1'b1;
      m_tlast <= 1'b0;
      m_tdata <= {3'b000, gbnms_pkg::SlotW'(idx)};
    end else if (load_final) begin
      m_tuser <= 1'b0;
      m_tlast <= 1'b1;
      if (!keep_flag) begin
        m_tdata <= '0;
      end else if (can_store) begin
        m_tdata <= {2'b00, 1'b1, gbnms_pkg::SlotW'(cnt)};
      end else begin
        m_tdata <= {2'b01, 1'b1, gbnms_pkg::SlotW'(0)} | 8'h40;
      end
    end
  end

endmodule

// ----- rtl/gbnms_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module gbnms_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/gbnms_checker.sv -----
// Port-level checker for the greedy box NMS unit, bound to the top level.
// Depends on gbnms_pkg and greedy_box_nms_with_merge_unit.
module gbnms_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           s_tvalid,
  input logic                           s_tready,
  input logic                           m_tvalid,
  input logic                           m_tready,
  input logic [gbnms_pkg::OutDataW-1:0] m_tdata,
  input logic                           m_tuser,
  input logic                           m_tlast
);

  // a merge notice is never the last result and carries no decision bits
  a_merge_shape : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> !m_tlast && m_tdata[6:5] == 2'b00)
    else $error("merge notice with decision bits or last");

  // every final decision closes the result run
  a_final_last : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("final decision without last");

  // store-full decisions are keeps with slot zero
  a_full_shape : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[6] |-> m_tdata[5] && m_tdata[4:0] == 5'd0)
    else $error("store_full without kept or with a slot");

  // one detection at a time: no accept right after an accept
  a_one_item : assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while previous detection in work");

  // stalled result holds
  a_out_hold : assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("stalled result changed");

endmodule

bind greedy_box_nms_with_merge_unit gbnms_checker u_gbnms_checker (.*);

// ----- tb/sv/tb_greedy_box_nms_with_merge_unit.sv -----
// Self-checking bench for greedy_box_nms_with_merge_unit: streams detections through
// the unit and checks every merge notice and decision against a kept-box tracker.
// Depends on gbnms_pkg and the unit RTL; no files, no arguments.
module tb_greedy_box_nms_with_merge_unit;
  import gbnms_pkg::*;

  localparam int KeptDepth = KeptDepthDefault;
  localparam int RandomItems = 210;
  // index outside the register map; the unit must drop such a write
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 2'd3;

  // receiver ready patterns
  localparam int RxAlways    = 0;
  localparam int RxCoin      = 1;
  localparam int RxMostly    = 2;
  localparam int RxLongStall = 3;

  // random frame shapes
  localparam int FrameNoise   = 0;
  localparam int FrameGrid    = 1;
  localparam int FrameCluster = 2;

  // register settings cycled through during the random part
  localparam int CfgAllMin   = 0;
  localparam int CfgAllMax   = 1;
  localparam int CfgRandom   = 2;
  localparam int CfgModerate = 3;

  // one detection; below frame_start the bits line up with s_tdata
  typedef struct packed {
    logic                     frame_start;
    logic [1:0]               color;
    logic [2:0]               cls;
    logic [ScoreW-1:0]        score;
    logic [SizeW-1:0]         h;
    logic [SizeW-1:0]         w;
    logic signed [CoordW-1:0] y;
    logic signed [CoordW-1:0] x;
  } det_t;

  // one result transaction
  typedef struct packed {
    logic             is_merge;
    logic [SlotW-1:0] slot;
    logic             kept;
    logic             store_full;
    logic             last;
  } decision_t;

  // Tracks the kept store and register values, and queues the results each
  // accepted detection must produce.
  class nms_tracker;
    logic [ThrW-1:0] nms_thr, merge_iou, merge_gap;
    det_t            kept_det[KeptDepth];
    int              kept_cnt;
    decision_t       expected_decisions[$];
    int              errors, detections, results, merges, fulls;

    function new();
      nms_thr    = NmsThrReset;
      merge_iou  = MergeIouReset;
      merge_gap  = MergeGapReset;
      kept_cnt   = 0;
      errors     = 0;
      detections = 0;
      results    = 0;
      merges     = 0;
      fulls      = 0;
    endfunction

    function void set_register(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] val);
      case (idx)
        CFG_NMS_THR:   nms_thr = val;
        CFG_MERGE_IOU: merge_iou = val;
        CFG_MERGE_GAP: merge_gap = val;
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_decisions.size();
    endfunction

    function void take_detection(det_t d);
      longint    ax, ay, aw, ah, area_a, bx, by, bw, bh;
      longint    x1, y1, x2, y2, inter, uni, diff;
      bit        keep, zero_union, over;
      int        merges_now, j;
      decision_t r;
      ax = longint'($signed(d.x));
      ay = longint'($signed(d.y));
      aw = longint'(d.w);
      ah = longint'(d.h);
      area_a = aw * ah;
      keep = 1'b1;
      merges_now = 0;
      detections++;
      if (d.frame_start) kept_cnt = 0;
      // oldest kept box first, same order as the unit's slot walk
      for (j = 0; j < kept_cnt; j++) begin
        bx = longint'($signed(kept_det[j].x));
        by = longint'($signed(kept_det[j].y));
        bw = longint'(kept_det[j].w);
        bh = longint'(kept_det[j].h);
        x1 = (ax > bx) ? ax : bx;
        y1 = (ay > by) ? ay : by;
        x2 = (ax + aw < bx + bw) ? ax + aw : bx + bw;
        y2 = (ay + ah < by + bh) ? ay + ah : by + bh;
        inter = 0;
        if (x2 > x1 && y2 > y1) inter = (x2 - x1) * (y2 - y1);
        uni = area_a + bw * bh - inter;
        zero_union = (uni <= 0);
        // IoU > T tested as inter * 2^16 > T * union, no division
        over = !zero_union && (inter * 65536 > longint'(nms_thr) * uni);
        if (zero_union || over) begin
          keep = 1'b0;
          diff = longint'(d.score) - longint'(kept_det[j].score);
          if (diff < 0) diff = -diff;
          if (!zero_union && inter * 65536 > longint'(merge_iou) * uni &&
              diff < longint'(merge_gap) && kept_det[j].cls == d.cls &&
              kept_det[j].color == d.color && merges_now < MaxMerges) begin
            r = '0;
            r.is_merge = 1'b1;
            r.slot = SlotW'(j);
            expected_decisions.insert(expected_decisions.size(), r);
            merges_now++;
          end
        end
      end
      r = '0;
      r.last = 1'b1;
      if (keep) begin
        r.kept = 1'b1;
        if (kept_cnt >= KeptDepth) begin
          r.store_full = 1'b1;  // survives but has nowhere to go
        end else begin
          kept_det[kept_cnt] = d;
          r.slot = SlotW'(kept_cnt);
          kept_cnt++;
        end
      end
      expected_decisions.insert(expected_decisions.size(), r);
    endfunction

    task report(string msg);
      if (errors < 60) $display("ERROR at %0t: %s", $time, msg);
      errors++;
    endtask

    task check_decision(decision_t got, logic pad);
      decision_t want;
      string     bad;
      results++;
      if (expected_decisions.size() == 0) begin
        report($sformatf("result with nothing pending: merge=%0d slot=%0d kept=%0d",
                         got.is_merge, got.slot, got.kept));
        return;
      end
      want = expected_decisions.pop_front();
      if (want.is_merge) merges++;
      if (want.store_full) fulls++;
      bad = "";
      if (got.is_merge !== want.is_merge) bad = {bad, " is_merge"};
      if (got.slot !== want.slot) bad = {bad, " slot"};
      if (got.kept !== want.kept) bad = {bad, " kept"};
      if (got.store_full !== want.store_full) bad = {bad, " store_full"};
      if (got.last !== want.last) bad = {bad, " last"};
      if (pad !== 1'b0) bad = {bad, " pad"};
      if (bad != "")
        report($sformatf("result %0d wrong:%s (got %0d/%0d/%0d/%0d/%0d want %0d/%0d/%0d/%0d/%0d)",
                         results, bad, got.is_merge, got.slot, got.kept, got.store_full,
                         got.last, want.is_merge, want.slot, want.kept, want.store_full,
                         want.last));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [InDataW-1:0]   s_tdata;   // box_x, box_y, box_w, box_h, score, class_id, color_id
  logic                 s_tuser;   // frame_start
  logic                 m_tvalid;
  logic                 m_tready;
  logic [OutDataW-1:0]  m_tdata;   // slot, kept, store_full, zero
  logic                 m_tuser;   // is_merge
  logic                 m_tlast;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CfgIdxW-1:0]   cfg_index;
  logic [ThrW-1:0]      cfg_data;

  nms_tracker tracker = new();

  // sender burst state, shared by the driving tasks
  int burst_left = 0;
  bit sender_steady = 1'b0;

  greedy_box_nms_with_merge_unit #(
    .KEPT_DEPTH(KeptDepth)
  ) dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Receiver: ready pattern switches between always-on, coin flip, mostly
  // ready and long stalls (a repeating pattern, low more often than high), each held for a random stretch.
  initial begin
    int mode, mode_left, cyc;
    m_tready = 1'b0;
    mode = RxAlways;
    mode_left = 0;
    cyc = 0;
    forever begin
      @(negedge clk);
      cyc++;
      if (mode_left == 0) begin
        mode = $urandom_range(RxAlways, RxLongStall);
        mode_left = $urandom_range(20, 200);
      end else begin
        mode_left--;
      end
      case (mode)
        RxAlways: m_tready <= 1'b1;
        RxCoin:   m_tready <= ($urandom_range(0, 1) == 1);
        RxMostly: m_tready <= ($urandom_range(0, 7) != 0);
        default:  m_tready <= ((cyc % 13) >= 9);
      endcase
    end
  end

  // Watchdog: far beyond the slowest legal run (full store, 33 results per
  // detection, every result held by a long stall).
  initial begin
    #8_000_000;
    $display("ERROR: run stopped at %0t, unit stopped making progress", $time);
    $display("*** FAILED ***");
    $finish;
  end

  // Monitor: every transaction is taken at the rising edge where it completes.
  always @(posedge clk) begin
    det_t      seen;
    decision_t got;
    if (!rst) begin
      if (cfg_valid && cfg_ready) tracker.set_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) begin
        seen.frame_start = s_tuser;
        seen.x     = s_tdata[12:0];
        seen.y     = s_tdata[25:13];
        seen.w     = s_tdata[37:26];
        seen.h     = s_tdata[49:38];
        seen.score = s_tdata[65:50];
        seen.cls   = s_tdata[68:66];
        seen.color = s_tdata[70:69];
        tracker.take_detection(seen);
      end
      if (m_tvalid && m_tready) begin
        got.is_merge   = m_tuser;
        got.slot       = m_tdata[4:0];
        got.kept       = m_tdata[5];
        got.store_full = m_tdata[6];
        got.last       = m_tlast;
        tracker.check_decision(got, m_tdata[7]);
      end
    end
  end

  function automatic int clamp(int v, int lo, int hi);
    return (v < lo) ? lo : (v > hi) ? hi : v;
  endfunction

  function automatic det_t make_det(bit fs, int x, int y, int w, int h, int sc,
                                    int cl, int co);
    det_t d;
    d.frame_start = fs;
    d.x     = 13'(x);
    d.y     = 13'(y);
    d.w     = 12'(w);
    d.h     = 12'(h);
    d.score = 16'(sc);
    d.cls   = 3'(cl);
    d.color = 2'(co);
    return d;
  endfunction

  // Sends one detection. Valid stays up across a burst; between bursts the
  // sender drops valid for a random gap unless it is in a steady stretch.
  task automatic push_detection(det_t d);
    int gap;
    if (burst_left == 0) begin
      gap = sender_steady ? 0 : $urandom_range(0, 9);
      if (gap > 0) begin
        @(negedge clk) s_tvalid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
      burst_left = $urandom_range(1, 8);
    end
    burst_left--;
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= d.frame_start;
    s_tdata  <= {1'b0, d.color, d.cls, d.score, d.h, d.w, d.y, d.x};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stop sending and let every pending result drain, so the sequencer is back
  // in idle before any register write.
  task automatic wait_idle();
    @(negedge clk) s_tvalid <= 1'b0;
    burst_left = 0;
    while (tracker.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [ThrW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  initial begin
    det_t d;
    int   k, n, p, r, frame_kind, since_cfg, rand_items, settings, sc, c, jit;
    int   x, y, w, h, cl, co;
    int   cx[3], cy[3], bs[3], ccls[3], ccol[3];
    int   ncenters;
    bit   fs;

    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_NMS_THR;
    cfg_data = '0;
    settings = 1;
    repeat (8) @(posedge clk);
    @(negedge clk) rst <= 1'b0;

    // --- directed, reset register values ---
    push_detection(make_det(1, -4096, -4096, 0, 0, 65535, 7, 3));  // empty box, slot 0
    push_detection(make_det(0, 500, 500, 0, 0, 65535, 7, 3));      // zero union: suppressed
    push_detection(make_det(0, 4095, 4095, 4095, 4095, 0, 0, 0));  // far corner, largest box
    push_detection(make_det(0, 100, 100, 50, 50, 60000, 1, 2));    // slot 2
    push_detection(make_det(0, 101, 100, 50, 50, 59000, 1, 2));    // merge into slot 2
    push_detection(make_det(0, 101, 100, 50, 50, 59000, 2, 2));    // class differs
    push_detection(make_det(0, 101, 100, 50, 50, 59000, 1, 1));    // color differs
    push_detection(make_det(0, 101, 100, 50, 50, 40000, 1, 2));    // score too far off
    push_detection(make_det(0, 101, 100, 50, 50, 50170, 1, 2));    // gap exactly at limit
    push_detection(make_det(0, 120, 100, 50, 50, 58000, 1, 2));    // IoU between thresholds
    push_detection(make_det(0, 140, 100, 50, 50, 57000, 1, 2));    // low IoU, kept
    push_detection(make_det(0, 150, 100, 10, 50, 56000, 1, 2));    // touches an edge
    push_detection(make_det(0, -4096, 4095, 4095, 0, 1, 5, 0));    // flat box

    // IoU exactly at threshold must not suppress
    wait_idle();
    write_reg(CFG_NMS_THR, 16'd32768);
    write_reg(CFG_MERGE_IOU, 16'd32768);
    settings++;
    push_detection(make_det(1, 0, 0, 60, 10, 30000, 3, 1));
    push_detection(make_det(0, 20, 0, 60, 10, 30000, 3, 1));   // IoU 0.5 exactly
    push_detection(make_det(0, 19, 0, 60, 10, 30000, 3, 1));   // above, two merges

    // --- full store and the most merges one detection can give ---
    // near-identical boxes all survive at the top threshold, so 32 are kept
    wait_idle();
    write_reg(CFG_NMS_THR, 16'hFFFF);
    write_reg(CFG_MERGE_IOU, MergeIouReset);
    settings++;
    for (k = 0; k < KeptDepth; k++)
      push_detection(make_det(k == 0, k, 0, 100, 100, 50000 - k * 10, 4, 1));
    push_detection(make_det(0, 2000, 2000, 100, 100, 40000, 4, 1));  // store full
    push_detection(make_det(0, 0, 0, 100, 100, 50000, 4, 1));        // twin of slot 0
    wait_idle();
    write_reg(CFG_NMS_THR, 16'd0);
    write_reg(CFG_MERGE_IOU, 16'd0);
    write_reg(CFG_MERGE_GAP, 16'hFFFF);
    settings++;
    push_detection(make_det(0, 0, 0, 100, 100, 49900, 4, 1));  // merges with all 32
    push_detection(make_det(0, 0, 0, 100, 100, 49900, 5, 1));  // same, other class

    // --- random frames under rotating register settings ---
    p = CfgModerate;
    since_cfg = 1000;
    rand_items = 0;
    while (rand_items < RandomItems) begin
      if (since_cfg >= 45) begin
        wait_idle();
        case (p % 5)
          CfgAllMin: begin
            write_reg(CFG_NMS_THR, 16'd0);
            write_reg(CFG_MERGE_IOU, 16'd0);
            write_reg(CFG_MERGE_GAP, 16'd0);
          end
          CfgAllMax: begin
            write_reg(CFG_NMS_THR, 16'hFFFF);
            write_reg(CFG_MERGE_IOU, 16'hFFFF);
            write_reg(CFG_MERGE_GAP, 16'hFFFF);
          end
          CfgRandom: begin
            write_reg(CFG_NMS_THR, 16'($urandom));
            write_reg(CFG_MERGE_IOU, 16'($urandom));
            write_reg(CFG_MERGE_GAP, 16'($urandom));
          end
          CfgModerate: begin
            write_reg(CFG_NMS_THR, 16'($urandom_range(8000, 40000)));
            write_reg(CFG_MERGE_IOU, 16'($urandom_range(40000, 65535)));
            write_reg(CFG_MERGE_GAP, 16'($urandom_range(2000, 30000)));
          end
          default: begin
            write_reg(CfgIdxUnused, 16'($urandom));  // must be dropped
            write_reg(CFG_NMS_THR, NmsThrReset);
            write_reg(CFG_MERGE_IOU, MergeIouReset);
            write_reg(CFG_MERGE_GAP, MergeGapReset);
          end
        endcase
        p++;
        settings++;
        since_cfg = 0;
        sender_steady = ($urandom_range(0, 3) == 0);
      end

      r = $urandom_range(0, 9);
      frame_kind = (r < 2) ? FrameNoise : (r == 2) ? FrameGrid : FrameCluster;
      case (frame_kind)
        FrameNoise: begin
          // every field fully random, frame_start included
          n = $urandom_range(2, 8);
          for (k = 0; k < n; k++) begin
            d = det_t'(72'({$urandom, $urandom, $urandom}));
            push_detection(d);
          end
        end
        FrameGrid: begin
          // disjoint boxes on a 1000-pixel grid: more than the store holds
          n = $urandom_range(KeptDepth + 1, KeptDepth + 4);
          sc = 65535;
          for (k = 0; k < n; k++) begin
            sc = clamp(sc - int'($urandom_range(0, 1500)), 0, 65535);
            push_detection(make_det(k == 0, -4096 + (k % 8) * 1000, -4096 + (k / 8) * 1000,
                                    $urandom_range(1, 900), $urandom_range(1, 900), sc,
                                    $urandom_range(0, 7), $urandom_range(0, 3)));
          end
        end
        default: begin
          // a few objects, each seen as several jittered boxes, scores falling
          n = $urandom_range(2, 14);
          ncenters = $urandom_range(1, 3);
          for (c = 0; c < 3; c++) begin
            cx[c] = int'($urandom_range(0, 7000)) - 4000;
            cy[c] = int'($urandom_range(0, 7000)) - 4000;
            bs[c] = ($urandom_range(0, 7) == 0) ? $urandom_range(300, 4095)
                                                : $urandom_range(1, 120);
            ccls[c] = $urandom_range(0, 7);
            ccol[c] = $urandom_range(0, 3);
          end
          sc = 65535;
          for (k = 0; k < n; k++) begin
            c = $urandom_range(0, ncenters - 1);
            jit = bs[c] / 8;
            x = clamp(cx[c] + int'($urandom_range(0, 2 * jit)) - jit, -4096, 4095);
            y = clamp(cy[c] + int'($urandom_range(0, 2 * jit)) - jit, -4096, 4095);
            w = clamp(bs[c] + int'($urandom_range(0, 2 * jit)) - jit, 0, 4095);
            h = clamp(bs[c] + int'($urandom_range(0, 2 * jit)) - jit, 0, 4095);
            if ($urandom_range(0, 15) == 0) w = 0;
            sc = clamp(sc - int'($urandom_range(0, 2500)), 0, 65535);
            cl = ccls[c];
            co = ccol[c];
            if ($urandom_range(0, 3) == 0) begin
              cl = $urandom_range(0, 7);
              co = $urandom_range(0, 3);
            end
            fs = (k == 0) && ($urandom_range(0, 9) != 0);
            push_detection(make_det(fs, x, y, w, h, sc, cl, co));
          end
        end
      endcase
      rand_items += n;
      since_cfg += n;
    end

    // drain, then give the unit time to show any stray result
    wait_idle();
    repeat (50) @(posedge clk);

    $display("Covered %0d detections and %0d results, %0d of them merge notices, %0d full-store keeps.",
             tracker.detections, tracker.results, tracker.merges, tracker.fulls);
    $display("Register settings used: %0d, with gaps and stalls on both streams.", settings);
    if (tracker.errors == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ----- files.f -----
rtl/gbnms_pkg.sv
rtl/gbnms_ram.sv
rtl/greedy_box_nms_with_merge_unit.sv
rtl/gbnms_checker.sv
tb/sv/tb_greedy_box_nms_with_merge_unit.sv
